// ===== hw/rtl/mos_pkg.sv =====
`default_nettype none

package mos_pkg;

  // fixed field widths of the words on the ports
  localparam int DATA_W      = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int STATUS_W    = 2;

  // defaults for the top-level parameters
  localparam int DEF_CAPACITY     = 64;
  localparam int DEF_SAMPLE_WIDTH = 32;

  // action codes
  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_UNIQUE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_UNIQUE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 2'd3;

  // token kinds moving down the cell chain
  localparam logic [1:0] TOK_BUBBLE = 2'd0;
  localparam logic [1:0] TOK_ADD    = 2'd1;
  localparam logic [1:0] TOK_FINISH = 2'd2;

  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] mode_value;
    logic [COUNT_OUT_W-1:0]   mode_count;
    logic [STATUS_W-1:0]      status;
  } out_word_t;

  // control part of a token handed from cell to cell
  typedef struct packed {
    logic [1:0] kind;
    logic       tie;      // top count seen more than once so far
    logic       empty;    // set had no kept samples at finish
    logic       dropped;  // an add was refused before finish
  } tok_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mos_cell.sv =====
`default_nettype none

module mos_cell import mos_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int CNT_W        = 7
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    advance,
  input  wire tok_ctl_t                ctl_in,
  input  wire logic [SAMPLE_WIDTH-1:0] value_in,
  input  wire logic [CNT_W-1:0]        top_in,
  output tok_ctl_t                     ctl_out,
  output logic [SAMPLE_WIDTH-1:0]      value_out,
  output logic [CNT_W-1:0]             top_out
);

  logic                    valid;
  logic [SAMPLE_WIDTH-1:0] val;
  logic [CNT_W-1:0]        cnt;

  logic                    valid_next;
  logic [SAMPLE_WIDTH-1:0] val_next;
  logic [CNT_W-1:0]        cnt_next;
  tok_ctl_t                ctl_next;
  logic [SAMPLE_WIDTH-1:0] value_next;
  logic [CNT_W-1:0]        top_next;
  logic                    hit;

  assign hit = valid && (val == value_in);

  always_comb begin
    valid_next = valid;
    val_next   = val;
    cnt_next   = cnt;
    ctl_next   = ctl_in;
    value_next = value_in;
    top_next   = top_in;
    case (ctl_in.kind)
      TOK_ADD: begin
        if (hit) begin
          cnt_next      = cnt + 1'b1;
          ctl_next.kind = TOK_BUBBLE;
        end else if (!valid) begin
          // first free cell takes the new value
          valid_next    = 1'b1;
          val_next      = value_in;
          cnt_next      = CNT_W'(1);
          ctl_next.kind = TOK_BUBBLE;
        end
      end
      TOK_FINISH: begin
        if (valid) begin
          valid_next = 1'b0;
          if (cnt > top_in) begin
            top_next     = cnt;
            value_next   = val;
            ctl_next.tie = 1'b0;
          end else if (cnt == top_in) begin
            ctl_next.tie = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      ctl_out <= '0;
    end else if (advance) begin
      valid   <= valid_next;
      ctl_out <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      val       <= val_next;
      cnt       <= cnt_next;
      value_out <= value_next;
      top_out   <= top_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mode_of_sample_set.sv =====
// channel   direction  handshake                     word
// sample    in         sample_valid / sample_stall   in_word_t  (action, sample_value)
// result    out        result_valid / result_stall   out_word_t (mode_value, mode_count, status)
//
// one word is taken per cycle while the chain is not halted, adds and finishes alike; tokens walk the cell chain
// a finish word's result is registered at the chain end once the finish token
// has swept the whole chain to fold counts and clear cells
// synchronous reset empties every cell at once, no clearing pass
// the chain only halts when a finish token reaches its end while the result
// register is still full and stalled; adds keep flowing until then
`default_nettype none

module mode_of_sample_set import mos_pkg::*; #(
  parameter int CAPACITY     = DEF_CAPACITY,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      sample_valid,
  output logic           sample_stall,
  input  wire in_word_t  sample_word,
  output logic           result_valid,
  input  wire logic      result_stall,
  output out_word_t      result_word
);

  // counts reach CAPACITY at most
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // token taps between cells; tap 0 is the intake, tap CAPACITY the chain end
  tok_ctl_t                ctl_chain   [CAPACITY+1];
  logic [SAMPLE_WIDTH-1:0] value_chain [CAPACITY+1];
  logic [CNT_W-1:0]        top_chain   [CAPACITY+1];

  logic             advance;
  logic             take;
  logic             finish_at_end;
  logic [CNT_W-1:0] sample_total;
  logic [CNT_W-1:0] sample_total_next;
  logic             dropped;
  logic             dropped_next;
  logic [SAMPLE_WIDTH-1:0] sample_fit;
  tok_ctl_t         ctl_head;
  logic [SAMPLE_WIDTH-1:0] value_head;
  out_word_t        result_next;

  // fit the incoming sample to the stored width
  generate
    if (SAMPLE_WIDTH >= DATA_W) begin : g_sample_wide
      assign sample_fit = SAMPLE_WIDTH'(sample_word.sample_value);
    end else begin : g_sample_narrow
      assign sample_fit = sample_word.sample_value[SAMPLE_WIDTH-1:0];
    end
  endgenerate

  // hold the chain only when a finished result has nowhere to go
  assign finish_at_end = (ctl_chain[CAPACITY].kind == TOK_FINISH);
  assign advance       = !(finish_at_end && result_valid && result_stall);
  assign sample_stall  = !advance;
  assign take          = sample_valid && advance;

  // intake: keep/drop decision and the token fed into the first cell
  always_comb begin
    sample_total_next = sample_total;
    dropped_next      = dropped;
    ctl_head          = '0;
    value_head        = '0;
    if (take) begin
      if (sample_word.action == ACT_FINISH) begin
        ctl_head.kind     = TOK_FINISH;
        ctl_head.empty    = (sample_total == '0);
        ctl_head.dropped  = dropped;
        sample_total_next = '0;
        dropped_next      = 1'b0;
      end else if (sample_total == CNT_W'(CAPACITY)) begin
        dropped_next = 1'b1;
      end else begin
        ctl_head.kind     = TOK_ADD;
        value_head        = sample_fit;
        sample_total_next = sample_total + 1'b1;
      end
    end
  end

  assign ctl_chain[0]   = ctl_head;
  assign value_chain[0] = value_head;
  assign top_chain[0]   = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_total <= '0;
      dropped      <= 1'b0;
    end else begin
      sample_total <= sample_total_next;
      dropped      <= dropped_next;
    end
  end

  // row of cells, one distinct value each
  generate
    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
      mos_cell #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CNT_W        (CNT_W)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .advance   (advance),
        .ctl_in    (ctl_chain[c]),
        .value_in  (value_chain[c]),
        .top_in    (top_chain[c]),
        .ctl_out   (ctl_chain[c+1]),
        .value_out (value_chain[c+1]),
        .top_out   (top_chain[c+1])
      );
    end
  endgenerate

  // result formed from the finish token at the chain end
  logic                     unique_mode;
  logic signed [DATA_W-1:0] winner_fit;
  logic [COUNT_OUT_W-1:0]   count_fit;

  generate
    if (SAMPLE_WIDTH >= DATA_W) begin : g_out_wide
      assign winner_fit = value_chain[CAPACITY][DATA_W-1:0];
    end else begin : g_out_narrow
      assign winner_fit = DATA_W'(value_chain[CAPACITY]);
    end
    if (CNT_W >= COUNT_OUT_W) begin : g_cnt_wide
      assign count_fit = top_chain[CAPACITY][COUNT_OUT_W-1:0];
    end else begin : g_cnt_narrow
      assign count_fit = COUNT_OUT_W'(top_chain[CAPACITY]);
    end
  endgenerate

  assign unique_mode = !ctl_chain[CAPACITY].tie && (top_chain[CAPACITY] != '0);

  always_comb begin
    result_next.mode_value = unique_mode ? winner_fit : '0;
    result_next.mode_count = count_fit;
    if (ctl_chain[CAPACITY].empty) begin
      result_next.status = ST_EMPTY;
    end else if (ctl_chain[CAPACITY].dropped) begin
      result_next.status = ST_DROPPED;
    end else if (ctl_chain[CAPACITY].tie) begin
      result_next.status = ST_NO_UNIQUE;
    end else begin
      result_next.status = ST_UNIQUE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && finish_at_end) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && finish_at_end) begin
      result_word <= result_next;
    end
  end

  // kept samples never exceed the number of cells
  assert property (@(posedge clk) disable iff (rst)
    sample_total <= CNT_W'(CAPACITY))
    else $error("kept sample count above capacity");

  // every add finds its cell before the chain end
  assert property (@(posedge clk) disable iff (rst)
    ctl_chain[CAPACITY].kind != TOK_ADD)
    else $error("add word fell off the cell chain");

  // a taken finish restarts the set
  assert property (@(posedge clk) disable iff (rst)
    take && sample_word.action == ACT_FINISH |=> sample_total == '0 && !dropped)
    else $error("set not cleared after finish");

  // a new result only follows a finish token leaving the chain
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(finish_at_end && advance))
    else $error("result without finish token");

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_word))
    else $error("pending result lost");

endmodule

`default_nettype wire

// ===== bench/mode_of_sample_set_tb.sv =====
`timescale 1ns / 100ps

module mode_of_sample_set_tb import mos_pkg::*;;

  localparam int CAP       = DEF_CAPACITY;
  localparam int PALETTE_N = 8;
  localparam int LONG_HOLD = 400;   // cycles the result side holds off under pressure

  // clock, reset and the two channels
  logic      clk;
  logic      rst          = 1'b1;
  logic      sample_valid = 1'b0;
  logic      sample_stall;
  in_word_t  sample_word  = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_word_t result_word;

  // run control shared by the sender, the receiver and the checker
  bit idle_on       = 1'b1;   // random idling on both sides
  bit long_hold_req = 1'b0;   // ask the receiver for one long hold-off
  int sent_words    = 0;
  int fail_count    = 0;

  // expected result words, oldest first
  out_word_t pending_modes[$];

  // running tally of the open set, values kept at the block's sample width
  logic [DATA_W-1:0] tally_values [CAP];
  int                tally_counts [CAP];
  int                tally_used    = 0;
  int                kept_samples  = 0;
  bit                set_overflowed = 1'b0;

  mode_of_sample_set #(
    .CAPACITY     (CAP),
    .SAMPLE_WIDTH (DEF_SAMPLE_WIDTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_word  (sample_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("mode_of_sample_set_tb: done, errors");
    $finish;
  end

  function automatic void flag_error(string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endfunction

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // an add: bump a matching cell, else open a new one; past capacity it is lost
  function automatic void tally_sample(logic [DATA_W-1:0] v);
    if (kept_samples >= CAP) begin
      set_overflowed = 1'b1;
      return;
    end
    kept_samples++;
    for (int i = 0; i < tally_used; i++) begin
      if (tally_values[i] == v) begin
        tally_counts[i]++;
        return;
      end
    end
    tally_values[tally_used] = v;
    tally_counts[tally_used] = 1;
    tally_used++;
  endfunction

  // a finish: strict top count wins, ties give zero; the set then starts over
  function automatic out_word_t close_set();
    out_word_t r;
    int        top;
    int        ties;
    int        winner;
    top    = 0;
    ties   = 0;
    winner = 0;
    for (int i = 0; i < tally_used; i++) begin
      if (tally_counts[i] > top) begin
        top    = tally_counts[i];
        ties   = 1;
        winner = i;
      end else if (tally_counts[i] == top) begin
        ties++;
      end
    end
    r.mode_value = '0;
    r.mode_count = top[COUNT_OUT_W-1:0];
    if (kept_samples == 0 && !set_overflowed) begin
      r.status = ST_EMPTY;
    end else if (ties == 1) begin
      r.mode_value = tally_values[winner];
      r.status     = set_overflowed ? ST_DROPPED : ST_UNIQUE;
    end else begin
      r.status = set_overflowed ? ST_DROPPED : ST_NO_UNIQUE;
    end
    tally_used     = 0;
    kept_samples   = 0;
    set_overflowed = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one word, hold it until taken, then update the prediction
  task automatic send_word(input logic act, input logic [DATA_W-1:0] val);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    sample_word  <= '{action: act, sample_value: val};
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    sent_words++;
    if (act == ACT_FINISH) pending_modes = {pending_modes, close_set()};
    else tally_sample(val);
  endtask

  // finish carries a random don't-care sample
  task automatic send_finish();
    send_word(ACT_FINISH, $urandom);
  endtask

  // mix of small signed values, the two extremes and fully random words
  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15) - 8;
      1: return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // one set drawn from a small palette, skewed toward the first entry so
  // unique modes show up as well as ties; now and then a set near or past capacity
  task automatic send_random_set(input int max_size);
    int                n_samples;
    int                n_kinds;
    logic [DATA_W-1:0] palette [PALETTE_N];
    n_kinds = $urandom_range(1, PALETTE_N);
    if (max_size > CAP && $urandom_range(0, 11) == 0) n_samples = $urandom_range(CAP - 4, CAP + 6);
    else n_samples = $urandom_range(0, (max_size > 20) ? 20 : max_size);
    foreach (palette[k]) palette[k] = pick_sample();
    repeat (n_samples) begin
      if ($urandom_range(0, 1) == 0) send_word(ACT_ADD, palette[0]);
      else send_word(ACT_ADD, palette[$urandom_range(0, n_kinds - 1)]);
    end
    send_finish();
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (pending_modes.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stall bursts, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : result_pacing
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        result_stall  <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every accepted result word against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_modes.size() == 0) begin
        flag_error($sformatf("unexpected result word: value %0d count %0d status %0d",
                             result_word.mode_value, result_word.mode_count,
                             result_word.status));
      end else begin
        want = pending_modes.pop_front();
        if (result_word.mode_value !== want.mode_value ||
            result_word.mode_count !== want.mode_count ||
            result_word.status !== want.status) begin
          flag_error($sformatf({"result mismatch: expected value %0d count %0d status %0d,",
                                " got value %0d count %0d status %0d"},
                               want.mode_value, want.mode_count, want.status,
                               result_word.mode_value, result_word.mode_count,
                               result_word.status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty set, single sample, ties, extremes and a finish right after a finish
  task automatic test_special_sets();
    send_finish();                                   // empty set
    send_word(ACT_ADD, 32'h7fff_ffff);               // single sample is its own mode
    send_finish();
    send_word(ACT_ADD, 32'h8000_0000);               // unique mode at the negative extreme
    send_word(ACT_ADD, 32'h8000_0000);
    send_word(ACT_ADD, 32'h0000_0000);
    send_finish();
    send_word(ACT_ADD, 32'hffff_ffff);               // all distinct, tie at one
    send_word(ACT_ADD, 32'h0000_0001);
    send_finish();
    send_word(ACT_ADD, 32'h5555_5555);               // tie at two, alternating bits
    send_word(ACT_ADD, 32'haaaa_aaaa);
    send_word(ACT_ADD, 32'h5555_5555);
    send_word(ACT_ADD, 32'haaaa_aaaa);
    send_finish();
    send_finish();                                   // finish cleared the store
    send_word(ACT_ADD, 32'h0000_0100);               // 1.0 beats -1.0
    send_word(ACT_ADD, 32'hffff_ff00);
    send_word(ACT_ADD, 32'h0000_0100);
    send_finish();
  endtask

  // full set, same value past capacity, all cells distinct, one over, and a drop that keeps a unique mode
  task automatic test_capacity_edges();
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] other;
    base = $urandom;
    repeat (CAP) send_word(ACT_ADD, base);           // count reaches its top
    send_finish();
    repeat (CAP + 5) send_word(ACT_ADD, base);       // same value past capacity
    send_finish();
    for (int i = 0; i < CAP; i++) send_word(ACT_ADD, base + i);   // every cell used
    send_finish();
    for (int i = 0; i <= CAP; i++) send_word(ACT_ADD, base + i);  // one dropped
    send_finish();
    other = ~base;
    for (int i = 0; i < CAP + 2; i++) send_word(ACT_ADD, (i % 3 == 0) ? other : base);
    send_finish();
  endtask

  task automatic test_random_sets(input int word_target);
    while (sent_words < word_target) send_random_set(CAP + 6);
  endtask

  // result side holds off while short sets keep coming, so a finish waits
  // at the end of the chain behind the held result and the block stalls its input
  task automatic test_result_hold_off();
    long_hold_req <= 1'b1;
    repeat (30) send_random_set(5);
  endtask

  // sender goes quiet until every expected result is back, then resumes
  task automatic test_sender_pause();
    repeat (3) send_random_set(12);
    wait_drained();
    repeat (3) send_random_set(12);
  endtask

  // last stretch with no idling at all
  task automatic test_steady_stream(input int word_target);
    idle_on = 1'b0;
    while (sent_words < word_target) send_random_set(CAP + 6);
  endtask

  initial begin : run_tests
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_special_sets();
    test_capacity_edges();
    test_random_sets(1150);
    test_result_hold_off();
    test_sender_pause();
    test_steady_stream(1450);

    // drain, then give a finish in flight time to show up unasked
    wait_drained();
    repeat (CAP + 8) @(posedge clk);
    if (pending_modes.size() != 0)
      flag_error($sformatf("%0d expected result words never arrived", pending_modes.size()));
    if (fail_count == 0) $display("mode_of_sample_set_tb: done, clean");
    else $display("mode_of_sample_set_tb: done, errors");
    $finish;
  end

endmodule
